FILE: rtl/tkce_pkg.sv
// Shared constants, types and codes for the keypad code entry unit.
`timescale 1ns / 1ps

package tkce_pkg;

	localparam int CHANNELS    = 12;
	localparam int MASK_BITS   = 12;
	localparam int CODE_DIGITS = 15;
	localparam int TIME_W      = 32;
	localparam int HOLD_W      = 16;
	localparam int CH_W        = 4;
	localparam int DIGIT_W     = 4;
	localparam int CODE_W      = DIGIT_W * CODE_DIGITS;
	localparam int LEN_W       = 4;
	localparam int ISSUE_W     = $clog2(CHANNELS + 1);

	localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(200);
	localparam logic [CH_W-1:0]   KEY_LAST_DIGIT = CH_W'(9);
	localparam logic [CH_W-1:0]   KEY_DELETE     = CH_W'(10);
	localparam logic [CH_W-1:0]   KEY_SUBMIT     = CH_W'(11);

	typedef enum logic [1:0] {
		KIND_LONG   = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_DELETE = 2'd2,
		KIND_SUBMIT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_RUN,
		SEQ_FLUSH
	} seq_state_t;

	typedef struct packed {
		logic [TIME_W-1:0] start_time;
		logic              done;
	} ch_state_t;

	typedef struct packed {
		logic                  en;
		logic [CH_W-1:0]       addr;
		ch_state_t             data;
	} ch_wr_t;

	typedef struct packed {
		kind_t               kind;
		logic [CH_W-1:0]     channel;
		logic [CODE_W-1:0]   code_digits;
		logic [LEN_W-1:0]    code_length;
		logic                last_of_scan;
	} result_t;

endpackage

FILE: rtl/tkce_ifs.sv
// Handshake interfaces for scan, result and configuration transactions.
`timescale 1ns / 1ps

interface tkce_scan_if import tkce_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [MASK_BITS-1:0] touch_mask;
	logic [TIME_W-1:0]    timestamp;

	modport source(output valid, touch_mask, timestamp, input ready);
	modport sink(input valid, touch_mask, timestamp, output ready);
endinterface

interface tkce_result_if import tkce_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [CH_W-1:0]   channel;
	logic [CODE_W-1:0] code_digits;
	logic [LEN_W-1:0]  code_length;
	logic              last_of_scan;

	modport source(output valid, kind, channel, code_digits, code_length, last_of_scan,
		input ready);
	modport sink(input valid, kind, channel, code_digits, code_length, last_of_scan,
		output ready);
endinterface

interface tkce_cfg_if import tkce_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [HOLD_W-1:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

FILE: rtl/tkce_chan_mem.sv
// Per-channel hold timer state RAM, registered read, valid bits for reset.
`timescale 1ns / 1ps

module tkce_chan_mem import tkce_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [CH_W-1:0] rd_addr,
	output ch_state_t       rd_data,
	input  ch_wr_t          wr
);

	ch_state_t             mem [CHANNELS];
	logic [CHANNELS-1:0]   vld_q;
	ch_state_t             rd_q;
	logic                  rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// unwritten entries read as unarmed
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

FILE: rtl/touch_keypad_code_entry_unit.sv
// Keypad code entry: per-channel press tracking, long press and digit code handling.
// Results: a result is held until the next one of its scan is found, so the last can be
// marked; the last one is sent from the flush state at the end of the channel pass.
// Scans: a new scan is taken only in idle; the channel pass reads the state RAM once per
// channel (12 reads), then a final flush; the pass stalls while results stall.
// Reset: arst_n clears masks, code, timers (through RAM valid bits) and sets hold_q to 200.
`timescale 1ns / 1ps

module touch_keypad_code_entry_unit import tkce_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	tkce_scan_if.sink     scan,
	tkce_result_if.source result,
	tkce_cfg_if.sink      cfg
);

	seq_state_t           state_q, state_nx;
	logic                 scan_rdy, run_en, flush_en;

	logic [HOLD_W-1:0]    hold_q;
	logic [MASK_BITS-1:0] mask_q, prev_q;
	logic [TIME_W-1:0]    time_q;
	logic [ISSUE_W-1:0]   issue_q;
	logic                 v_s1;
	logic [CH_W-1:0]      ch_s1;
	logic [CODE_W-1:0]    code_q;
	logic [LEN_W-1:0]     cnt_q;
	result_t              pend_q, out_q;
	logic                 pend_v_q, out_v_q;

	ch_state_t            rd;
	ch_wr_t               wr;
	logic                 issue, adv, stall, out_free, last_ch;
	logic                 cur, prv, rose, fell, held, act;
	logic [TIME_W-1:0]    elapsed;
	ch_state_t            st_new;
	logic                 emit;
	kind_t                ekind;
	logic [CODE_W-1:0]    ecode, code_nx;
	logic [LEN_W-1:0]     elen, cnt_nx;
	logic                 out_load;
	result_t              out_src;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HOLD_RESET;
		end else if (cfg.valid) begin
			hold_q <= cfg.data;
		end
	end

	// sequencer
	always_comb begin
		state_nx = state_q;
		case (state_q)
			SEQ_IDLE: begin
				if (scan.valid) state_nx = SEQ_RUN;
			end
			SEQ_RUN: begin
				if (adv && last_ch) state_nx = SEQ_FLUSH;
			end
			SEQ_FLUSH: begin
				if (!pend_v_q || out_free) state_nx = SEQ_IDLE;
			end
			default: state_nx = SEQ_IDLE;
		endcase
	end

	always_comb begin
		scan_rdy = 1'b0;
		run_en   = 1'b0;
		flush_en = 1'b0;
		case (state_q)
			SEQ_IDLE:  scan_rdy = 1'b1;
			SEQ_RUN:   run_en   = 1'b1;
			SEQ_FLUSH: flush_en = 1'b1;
			default: ;
		endcase
	end

	assign scan.ready = scan_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign out_free = !out_v_q || result.ready;
	assign last_ch  = (ch_s1 == CH_W'(CHANNELS - 1));
	assign stall    = emit && pend_v_q && !out_free;
	assign adv      = v_s1 && !stall;
	assign issue    = run_en && (issue_q != ISSUE_W'(CHANNELS)) && (!v_s1 || adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			prev_q  <= '0;
			issue_q <= '0;
			v_s1    <= 1'b0;
			ch_s1   <= '0;
		end else begin
			if (scan_rdy && scan.valid) begin
				prev_q  <= mask_q;
				mask_q  <= scan.touch_mask;
				issue_q <= '0;
			end else if (issue) begin
				issue_q <= issue_q + ISSUE_W'(1);
			end
			if (issue) begin
				v_s1  <= 1'b1;
				ch_s1 <= issue_q[CH_W-1:0];
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_rdy && scan.valid) begin
			time_q <= scan.timestamp;
		end
	end

	tkce_chan_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (issue),
		.rd_addr (issue_q[CH_W-1:0]),
		.rd_data (rd),
		.wr      (wr)
	);

	// channel evaluation
	always_comb begin
		cur     = mask_q[ch_s1];
		prv     = prev_q[ch_s1];
		rose    = cur && !prv;
		fell    = !cur && prv;
		elapsed = time_q - rd.start_time;
		held    = cur && !rd.done && (rd.start_time != '0) &&
			(elapsed >= {{(TIME_W-HOLD_W){1'b0}}, hold_q});
		act     = fell && !rd.done;

		st_new.done       = held ? 1'b1 : (rose ? 1'b0 : rd.done);
		st_new.start_time = rose ? time_q : (act ? '0 : rd.start_time);

		emit    = 1'b0;
		ekind   = KIND_LONG;
		ecode   = code_q;
		elen    = cnt_q;
		code_nx = code_q;
		cnt_nx  = cnt_q;

		if (held) begin
			emit = 1'b1;
		end else if (act) begin
			if (ch_s1 <= KEY_LAST_DIGIT) begin
				if (cnt_q < LEN_W'(CODE_DIGITS)) begin
					emit  = 1'b1;
					ekind = KIND_APPEND;
					for (int k = 0; k < CODE_DIGITS; k++) begin
						if (cnt_q == LEN_W'(k)) ecode[k*DIGIT_W +: DIGIT_W] = ch_s1;
					end
					elen    = cnt_q + LEN_W'(1);
					code_nx = ecode;
					cnt_nx  = elen;
				end
			end else if (ch_s1 == KEY_DELETE) begin
				if (cnt_q != '0) begin
					emit  = 1'b1;
					ekind = KIND_DELETE;
					for (int k = 0; k < CODE_DIGITS; k++) begin
						if (cnt_q == LEN_W'(k + 1)) ecode[k*DIGIT_W +: DIGIT_W] = '0;
					end
					elen    = cnt_q - LEN_W'(1);
					code_nx = ecode;
					cnt_nx  = elen;
				end
			end else if (ch_s1 == KEY_SUBMIT) begin
				if (cnt_q != '0) begin
					emit    = 1'b1;
					ekind   = KIND_SUBMIT;
					code_nx = '0;
					cnt_nx  = '0;
				end
			end
		end

		wr.en   = adv;
		wr.addr = ch_s1;
		wr.data = st_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= '0;
			cnt_q  <= '0;
		end else if (adv) begin
			code_q <= code_nx;
			cnt_q  <= cnt_nx;
		end
	end

	// pending result waits for the next one (or scan end) to know last_of_scan
	assign out_load = pend_v_q && out_free && ((adv && emit) || flush_en);

	always_comb begin
		out_src              = pend_q;
		out_src.last_of_scan = flush_en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (adv && emit) begin
				pend_v_q <= 1'b1;
			end else if (out_load) begin
				pend_v_q <= 1'b0;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			pend_q.kind         <= ekind;
			pend_q.channel      <= ch_s1;
			pend_q.code_digits  <= ecode;
			pend_q.code_length  <= elen;
			pend_q.last_of_scan <= 1'b0;
		end
		if (out_load) begin
			out_q <= out_src;
		end
	end

	assign result.valid        = out_v_q;
	assign result.kind         = out_q.kind;
	assign result.channel      = out_q.channel;
	assign result.code_digits  = out_q.code_digits;
	assign result.code_length  = out_q.code_length;
	assign result.last_of_scan = out_q.last_of_scan;

endmodule
